// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge, off while reset is asserted
`define ASSERT_ON(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never be seen on a rising clk edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/pcmk_pkg.sv =====
// shared types, codes and constants of the memory map and keyboard block
package pcmk_pkg;

	localparam int MatrixLines = 13;
	localparam int LineW = 4;

	typedef enum logic [1:0] {
		ACT_CPU_WRITE = 2'd0,
		ACT_CPU_READ  = 2'd1,
		ACT_PORT_READ = 2'd2,
		ACT_KEY_EVENT = 2'd3
	} action_t;

	localparam logic [15:0] LCD_BASE    = 16'h3000;
	localparam logic [15:0] LCD_LAST    = 16'h30FF;
	localparam logic [15:0] IO_LAST     = 16'h3BFF;
	localparam logic [15:0] BANK_BASE   = 16'h3C00;
	localparam logic [15:0] BANK_LAST   = 16'h3DFF;
	localparam logic [15:0] STROBE_BASE = 16'h3E00;
	localparam logic [15:0] STROBE_LAST = 16'h3FFF;
	localparam logic [15:0] ROM_BASE    = 16'h4000;
	localparam logic [15:0] ROM_LAST    = 16'h7FFF;
	localparam logic [15:0] RAM_BASE    = 16'h8000;
	localparam logic [15:0] EXT_LAST    = 16'hDFFF;
	localparam logic [16:0] ROM_OFFSET  = 17'h0C000;
	localparam logic [16:0] MIRROR_BASE = 17'h0E000;
	localparam logic [7:0]  BANK_MIN    = 8'h09;
	localparam logic [7:0]  BANK_MAX    = 8'h0B;
	localparam logic [7:0]  BANK_ZERO_A = 8'h00;
	localparam logic [7:0]  BANK_ZERO_B = 8'h08;

	// result of decoding one cpu access
	typedef struct packed {
		logic [16:0] mapped;
		logic        wr;
		logic        dirty;
		logic [7:0]  off;
		logic        bank_we;
		logic [1:0]  bank_val;
		logic        strobe_we;
	} dec_t;

	// columns wired for each matrix line
	function automatic logic [7:0] wired_cols(input logic [LineW-1:0] line);
		logic [7:0] cols;
		unique case (line)
			4'd0:                   cols = 8'h1F;
			4'd1, 4'd2, 4'd3:       cols = 8'hFF;
			4'd4, 4'd5, 4'd6:       cols = 8'hEF;
			4'd7:                   cols = 8'hFE;
			4'd8:                   cols = 8'hFC;
			4'd9:                   cols = 8'hF8;
			4'd10:                  cols = 8'hF0;
			4'd11:                  cols = 8'hE0;
			4'd12:                  cols = 8'h80;
			default:                cols = 8'h00;
		endcase
		return cols;
	endfunction

endpackage

// ===== hw/rtl/pocket_computer_memory_map_and_keys.sv =====
// top level: pocket computer address decoder, rom bank switch and key matrix
// One request per clock unless out_ready stalls. Each accepted request is decoded
// in the cycle it is accepted, from the bank, strobe and key matrix registers as
// they stand, and its result appears on the output register in the next cycle;
// the registers themselves take the request's side effects at the same edge, so
// the next request already sees them. Input is taken whenever the output register
// is empty or is being emptied in the same cycle, so with out_ready held high the
// block runs at one request per cycle.
// The extended-ram bit is written through the cfg channel, which is always
// ready. The 13 x 8 key matrix is plain flip-flops cleared by reset.
`include "assert_macros.svh"

module pocket_computer_memory_map_and_keys (
	input  logic        clk,
	input  logic        arst_n,

	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,

	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	input  logic [5:0]  port_a_lines,
	input  logic [3:0]  key_line,
	input  logic [2:0]  key_column,
	input  logic        key_pressed,

	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [16:0] mapped_address,
	output logic        writable,
	output logic        lcd_dirty,
	output logic [7:0]  lcd_offset,
	output logic [7:0]  port_a_data
);

	// state
	logic       ext_ram_q;
	logic [1:0] rom_bank_q;
	logic [6:0] key_strobe_q;
	logic       port_high_q;
	logic [7:0] key_matrix_q [pcmk_pkg::MatrixLines];

	// output register
	logic        out_valid_q;
	logic [16:0] mapped_s1;
	logic        writable_s1;
	logic        dirty_s1;
	logic [7:0]  offset_s1;
	logic [7:0]  port_s1;

	logic           accept;
	pcmk_pkg::dec_t dec;
	logic           is_write;
	logic           is_read;
	logic           is_port;
	logic           is_key;
	logic [7:0]     port_or;
	logic [7:0]     key_bit;
	logic           key_hit;
	logic           unwired_set;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;

	assign is_write = (action == pcmk_pkg::ACT_CPU_WRITE);
	assign is_read  = (action == pcmk_pkg::ACT_CPU_READ);
	assign is_port  = (action == pcmk_pkg::ACT_PORT_READ);
	assign is_key   = (action == pcmk_pkg::ACT_KEY_EVENT);

	pcmk_decode u_decode (
		.ext_ram    (ext_ram_q),
		.rom_bank   (rom_bank_q),
		.address    (address),
		.write_data (write_data),
		.dec        (dec)
	);

	// port a: or of the columns on every active line, strobe lines 0-6 and
	// port lines 7-12, plus the high port bit
	always_comb begin
		port_or = {port_high_q, 7'd0};
		for (int i = 0; i < 7; i++) begin
			if (key_strobe_q[i]) begin
				port_or = port_or | key_matrix_q[i];
			end
		end
		for (int i = 0; i < 6; i++) begin
			if (port_a_lines[i]) begin
				port_or = port_or | key_matrix_q[7 + i];
			end
		end
	end

	// key event: lines beyond the matrix and unwired columns are dropped
	assign key_bit = 8'd1 << key_column;
	assign key_hit = (key_line < 4'(pcmk_pkg::MatrixLines))
		&& ((pcmk_pkg::wired_cols(key_line) & key_bit) != 8'd0);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_ram_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			ext_ram_q <= cfg_data;
		end
	end

	// bank, strobe and high port bit, changed by writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q   <= 2'd0;
			key_strobe_q <= 7'd0;
			port_high_q  <= 1'b0;
		end else if (accept && is_write) begin
			if (dec.bank_we) begin
				rom_bank_q <= dec.bank_val;
			end
			if (dec.strobe_we) begin
				key_strobe_q <= write_data[6:0];
				port_high_q  <= write_data[7];
			end
		end
	end

	// key matrix, one cell per key event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pcmk_pkg::MatrixLines; i++) begin
				key_matrix_q[i] <= 8'd0;
			end
		end else if (accept && is_key && key_hit) begin
			if (key_pressed) begin
				key_matrix_q[key_line] <= key_matrix_q[key_line] | key_bit;
			end else begin
				key_matrix_q[key_line] <= key_matrix_q[key_line] & ~key_bit;
			end
		end
	end

	// result register; fields an action does not produce are zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mapped_s1   <= (is_write || is_read) ? dec.mapped : 17'd0;
			writable_s1 <= is_write && dec.wr;
			dirty_s1    <= is_write && dec.dirty;
			offset_s1   <= is_write ? dec.off : 8'd0;
			port_s1     <= is_port ? port_or : 8'd0;
		end
	end

	assign out_valid      = out_valid_q;
	assign mapped_address = mapped_s1;
	assign writable       = writable_s1;
	assign lcd_dirty      = dirty_s1;
	assign lcd_offset     = offset_s1;
	assign port_a_data    = port_s1;

	// any pressed cell outside the wired columns
	always_comb begin
		unwired_set = 1'b0;
		for (int i = 0; i < pcmk_pkg::MatrixLines; i++) begin
			if ((key_matrix_q[i] & ~pcmk_pkg::wired_cols(4'(i))) != 8'd0) begin
				unwired_set = 1'b1;
			end
		end
	end

	// checks
	`ASSERT_NEVER(a_unwired_key, unwired_set, "key set at an unwired matrix position")
	`ASSERT_ON(a_dirty_writable, out_valid && lcd_dirty |-> writable, "display write not writable")
	`ASSERT_ON(a_port_only, out_valid && port_a_data != 8'd0 |-> !writable && mapped_address == 17'd0, "port data on a cpu access")
	`ASSERT_ON(a_strobe_load, accept && is_write && address >= pcmk_pkg::STROBE_BASE && address <= pcmk_pkg::STROBE_LAST |=> key_strobe_q == $past(write_data[6:0]), "strobe write not taken")

endmodule

// ===== hw/rtl/pcmk_decode.sv =====
// address translation and write decode of one cpu access
module pcmk_decode (
	input  logic              ext_ram,
	input  logic [1:0]        rom_bank,
	input  logic [15:0]       address,
	input  logic [7:0]        write_data,
	output pcmk_pkg::dec_t    dec
);

	logic ext_hit;

	assign ext_hit = ext_ram && (address >= pcmk_pkg::RAM_BASE)
		&& (address <= pcmk_pkg::EXT_LAST);

	always_comb begin
		dec = '0;

		// translation
		if (ext_hit) begin
			dec.mapped = {1'b0, address};
		end else if (address >= pcmk_pkg::ROM_BASE && address <= pcmk_pkg::ROM_LAST) begin
			dec.mapped = {1'b0, address} + pcmk_pkg::ROM_OFFSET + {1'b0, rom_bank, 14'd0};
		end else if (address >= pcmk_pkg::RAM_BASE) begin
			dec.mapped = pcmk_pkg::MIRROR_BASE | {4'd0, address[12:0]};
		end else begin
			dec.mapped = {1'b0, address};
		end

		// write side effects
		priority if (ext_hit) begin
			dec.wr = 1'b1;
		end else if (address < pcmk_pkg::LCD_BASE) begin
			dec.wr = 1'b0;
		end else if (address <= pcmk_pkg::LCD_LAST) begin
			dec.wr    = 1'b1;
			dec.dirty = 1'b1;
			dec.off   = address[7:0];
		end else if (address <= pcmk_pkg::IO_LAST) begin
			dec.wr = 1'b1;
		end else if (address <= pcmk_pkg::BANK_LAST) begin
			dec.wr = 1'b1;
			if (write_data == pcmk_pkg::BANK_ZERO_A || write_data == pcmk_pkg::BANK_ZERO_B) begin
				dec.bank_we  = 1'b1;
				dec.bank_val = 2'd0;
			end else if (write_data >= pcmk_pkg::BANK_MIN
				&& write_data <= pcmk_pkg::BANK_MAX) begin
				// 0x09..0x0b give banks 1..3
				dec.bank_we  = 1'b1;
				dec.bank_val = write_data[1:0];
			end
		end else if (address <= pcmk_pkg::STROBE_LAST) begin
			dec.wr        = 1'b1;
			dec.strobe_we = 1'b1;
		end else if (address <= pcmk_pkg::ROM_LAST) begin
			dec.wr = 1'b0;
		end else begin
			dec.wr = 1'b1;
		end
	end

endmodule

// ===== tb/sv/pocket_computer_memory_map_and_keys_tb.sv =====
// testbench for the pocket computer address decoder, bank switch and key matrix
import pcmk_pkg::*;

// one request as driven onto the input channel
typedef struct packed {
	action_t     act;
	logic [15:0] address;
	logic [7:0]  data;
	logic [5:0]  lines;
	logic [3:0]  kline;
	logic [2:0]  kcol;
	logic        kdown;
} map_request_t;

// one result as seen on the output channel
typedef struct packed {
	logic [16:0] mapped;
	logic        wr;
	logic        dirty;
	logic [7:0]  off;
	logic [7:0]  port;
} map_result_t;

// tracks the decoder and keyboard state and the results still owed
class map_key_scoreboard;
	bit          ext_ram;
	bit [1:0]    bank;
	bit [6:0]    strobe;
	bit          high_bit;
	bit [7:0]    matrix [MatrixLines];
	bit [7:0]    line_columns [MatrixLines] = '{8'h1F, 8'hFF, 8'hFF, 8'hFF, 8'hEF, 8'hEF,
		8'hEF, 8'hFE, 8'hFC, 8'hF8, 8'hF0, 8'hE0, 8'h80};
	map_result_t owed_results [$];
	int          error_count;

	function void set_extended_ram(bit v);
		ext_ram = v;
	endfunction

	function int pending();
		return owed_results.size();
	endfunction

	function bit [16:0] map_address(bit [15:0] a);
		if (ext_ram && a >= RAM_BASE && a <= EXT_LAST)
			return {1'b0, a};
		if (a >= ROM_BASE && a <= ROM_LAST)
			return {1'b0, a} + ROM_OFFSET + 17'h04000 * bank;
		if (a >= RAM_BASE)
			return {4'b0, a[12:0]} | MIRROR_BASE;
		return {1'b0, a};
	endfunction

	// work out the result of an accepted request and apply its side effects
	function void note_request(map_request_t r);
		map_result_t e;
		e = '0;
		case (r.act)
			ACT_CPU_WRITE: begin
				e.mapped = map_address(r.address);
				if (ext_ram && r.address >= RAM_BASE && r.address <= EXT_LAST) begin
					e.wr = 1'b1;
				end else if (r.address < LCD_BASE) begin
					e.wr = 1'b0;
				end else if (r.address <= LCD_LAST) begin
					e.wr = 1'b1;
					e.dirty = 1'b1;
					e.off = r.address[7:0];
				end else if (r.address <= IO_LAST) begin
					e.wr = 1'b1;
				end else if (r.address <= BANK_LAST) begin
					if (r.data == BANK_ZERO_A || r.data == BANK_ZERO_B)
						bank = 2'd0;
					else if (r.data >= BANK_MIN && r.data <= BANK_MAX)
						bank = 2'(r.data - BANK_ZERO_B);
					e.wr = 1'b1;
				end else if (r.address <= STROBE_LAST) begin
					high_bit = r.data[7];
					strobe = r.data[6:0];
					e.wr = 1'b1;
				end else begin
					e.wr = (r.address > ROM_LAST);
				end
			end
			ACT_CPU_READ: begin
				e.mapped = map_address(r.address);
			end
			ACT_PORT_READ: begin
				for (int i = 0; i < 7; i++)
					if (strobe[i])
						e.port |= matrix[i];
				for (int i = 0; i < 6; i++)
					if (r.lines[i])
						e.port |= matrix[7 + i];
				if (high_bit)
					e.port |= 8'h80;
			end
			default: begin
				if (r.kline < MatrixLines && line_columns[r.kline][r.kcol])
					matrix[r.kline][r.kcol] = r.kdown;
			end
		endcase
		owed_results.push_back(e);
	endfunction

	function void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			error_count++;
			if (error_count <= 10)
				$display("mismatch on %s: expected 0x%0h, got 0x%0h", name, want, got);
		end
	endfunction

	function void check_result(map_result_t got);
		map_result_t want;
		if (owed_results.size() == 0) begin
			error_count++;
			if (error_count <= 10)
				$display("result 0x%0h arrived with no request outstanding", got);
			return;
		end
		want = owed_results.pop_front();
		compare_field("mapped_address", want.mapped, got.mapped);
		compare_field("writable", want.wr, got.wr);
		compare_field("lcd_dirty", want.dirty, got.dirty);
		compare_field("lcd_offset", want.off, got.off);
		compare_field("port_a_data", want.port, got.port);
	endfunction
endclass

module pocket_computer_memory_map_and_keys_tb;

	// generous bound on the length of the run, far above what the slowest phases need
	localparam int CycleLimit = 200000;
	localparam int PhaseRequests = 210;
	// edges of the address regions, written and read on purpose now and then
	localparam logic [15:0] RegionEdges [15] = '{16'h0000, 16'h2FFF, 16'h3000, 16'h30FF,
		16'h3100, 16'h3BFF, 16'h3C00, 16'h3DFF, 16'h3E00, 16'h3FFF, 16'h4000, 16'h7FFF,
		16'h8000, 16'hDFFF, 16'hFFFF};

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_data;
	logic in_valid;
	logic in_ready;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [16:0] mapped_address;
	logic writable;
	logic lcd_dirty;
	logic [7:0] lcd_offset;
	logic [7:0] port_a_data;

	// request currently on the input channel
	map_request_t bus_req;

	// percent chance per cycle that the sender idles or the receiver stalls
	int idle_pct;
	int stall_pct;
	int cycle_count;
	map_key_scoreboard sb;

	pocket_computer_memory_map_and_keys dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(bus_req.act),
		.address(bus_req.address),
		.write_data(bus_req.data),
		.port_a_lines(bus_req.lines),
		.key_line(bus_req.kline),
		.key_column(bus_req.kcol),
		.key_pressed(bus_req.kdown),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mapped_address(mapped_address),
		.writable(writable),
		.lcd_dirty(lcd_dirty),
		.lcd_offset(lcd_offset),
		.port_a_data(port_a_data)
	);

	// period of two time units
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("pocket_computer_memory_map_and_keys_tb: FAIL");
			$finish;
		end
	end

	// receiver back-pressure, changed only at the falling edge
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// everything is sampled at the rising edge; results are checked before the
	// request accepted at the same edge is noted, though latency keeps them apart
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result({mapped_address, writable, lcd_dirty, lcd_offset,
					port_a_data});
			if (in_valid && in_ready)
				sb.note_request(bus_req);
			if (cfg_valid && cfg_ready)
				sb.set_extended_ram(cfg_data);
		end
	end

	function automatic map_request_t make_req(action_t act, logic [15:0] address,
			logic [7:0] data, logic [5:0] lines, logic [3:0] kline, logic [2:0] kcol,
			logic kdown);
		map_request_t r;
		r.act = act;
		r.address = address;
		r.data = data;
		r.lines = lines;
		r.kline = kline;
		r.kcol = kcol;
		r.kdown = kdown;
		return r;
	endfunction

	// addresses biased toward the regions and their boundaries
	function automatic logic [15:0] pick_address();
		case ($urandom_range(8))
			0: return 16'($urandom_range(16'h2FFF, 16'h0000));
			1: return 16'($urandom_range(16'h30FF, 16'h3000));
			2: return 16'($urandom_range(16'h3BFF, 16'h3100));
			3: return 16'($urandom_range(16'h3DFF, 16'h3C00));
			4: return 16'($urandom_range(16'h3FFF, 16'h3E00));
			5: return 16'($urandom_range(16'h7FFF, 16'h4000));
			6: return 16'($urandom_range(16'hFFFF, 16'h8000));
			7: return RegionEdges[$urandom_range(14)];
			default: return 16'($urandom);
		endcase
	endfunction

	// random request; unused fields carry noise as well
	function automatic map_request_t random_request();
		map_request_t r;
		int sel;
		r = make_req(ACT_CPU_WRITE, 16'($urandom), 8'($urandom), 6'($urandom),
			4'($urandom), 3'($urandom), 1'($urandom));
		sel = $urandom_range(99);
		if (sel < 25) begin
			// key events mostly on wired lines so port reads see pressed keys
			r.act = ACT_KEY_EVENT;
			r.kline = ($urandom_range(99) < 85) ? 4'($urandom_range(12)) :
				4'($urandom_range(15, 13));
			r.kdown = ($urandom_range(99) < 60);
		end else if (sel < 45) begin
			r.act = ACT_PORT_READ;
		end else if (sel < 75) begin
			r.act = ACT_CPU_WRITE;
			r.address = pick_address();
			// bank select writes mostly carry one of the recognized codes
			if (r.address >= BANK_BASE && r.address <= BANK_LAST && $urandom_range(3) != 0)
			begin
				case ($urandom_range(4))
					0: r.data = BANK_ZERO_A;
					1: r.data = BANK_ZERO_B;
					default: r.data = 8'($urandom_range(BANK_MAX, BANK_MIN));
				endcase
			end
		end else begin
			r.act = ACT_CPU_READ;
			r.address = pick_address();
		end
		return r;
	endfunction

	// entered and left at a falling edge; idles first, then holds until accepted
	task automatic send_request(map_request_t r);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		bus_req <= r;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// only while the block is idle: no new request, every owed result out first
	task automatic write_extended_ram(bit v);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		map_request_t directed [$];
		sb = new;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		in_valid = 1'b0;
		bus_req = '0;
		idle_pct = 0;
		stall_pct = 0;
		cycle_count = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// write map: unwritable low area, display memory ends, plain i/o
		directed.push_back(make_req(ACT_CPU_WRITE, 16'h0000, 8'h00, 6'h00, 4'h0, 3'h0, 1'b0));
		directed.push_back(make_req(ACT_CPU_WRITE, 16'h2FFF, 8'hFF, 6'h3F, 4'hF, 3'h7, 1'b1));
		directed.push_back(make_req(ACT_CPU_WRITE, 16'h3000, 8'hA5, 6'h00, 4'h0, 3'h0, 1'b0));
		directed.push_back(make_req(ACT_CPU_WRITE, 16'h30FF, 8'h5A, 6'h00, 4'h0, 3'h0, 1'b0));
		directed.push_back(make_req(ACT_CPU_WRITE, 16'h3100, 8'h01, 6'h00, 4'h0, 3'h0, 1'b0));
		// bank select: known codes, an unknown code leaves the bank alone
		directed.push_back(make_req(ACT_CPU_WRITE, 16'h3C00, 8'h0B, 6'h00, 4'h0, 3'h0, 1'b0));
		directed.push_back(make_req(ACT_CPU_READ, 16'h7FFF, 8'h00, 6'h00, 4'h0, 3'h0, 1'b0));
		directed.push_back(make_req(ACT_CPU_WRITE, 16'h3DFF, 8'h55, 6'h00, 4'h0, 3'h0, 1'b0));
		directed.push_back(make_req(ACT_CPU_WRITE, 16'h4000, 8'h00, 6'h00, 4'h0, 3'h0, 1'b0));
		directed.push_back(make_req(ACT_CPU_WRITE, 16'h3C00, 8'h09, 6'h00, 4'h0, 3'h0, 1'b0));
		directed.push_back(make_req(ACT_CPU_READ, 16'h4000, 8'h00, 6'h00, 4'h0, 3'h0, 1'b0));
		directed.push_back(make_req(ACT_CPU_WRITE, 16'h3BFF, 8'h08, 6'h00, 4'h0, 3'h0, 1'b0));
		directed.push_back(make_req(ACT_CPU_WRITE, 16'h3C00, 8'h08, 6'h00, 4'h0, 3'h0, 1'b0));
		// ram mirror at both ends and an untranslated low read
		directed.push_back(make_req(ACT_CPU_WRITE, 16'h8000, 8'h00, 6'h00, 4'h0, 3'h0, 1'b0));
		directed.push_back(make_req(ACT_CPU_WRITE, 16'hFFFF, 8'hFF, 6'h00, 4'h0, 3'h0, 1'b0));
		directed.push_back(make_req(ACT_CPU_READ, 16'hDFFF, 8'h00, 6'h00, 4'h0, 3'h0, 1'b0));
		directed.push_back(make_req(ACT_CPU_READ, 16'h1234, 8'h00, 6'h00, 4'h0, 3'h0, 1'b0));
		// keys: wired cells, an unwired column and an out-of-range line
		directed.push_back(make_req(ACT_KEY_EVENT, 16'h0000, 8'h00, 6'h00, 4'd3, 3'd2, 1'b1));
		directed.push_back(make_req(ACT_KEY_EVENT, 16'h0000, 8'h00, 6'h00, 4'd12, 3'd7, 1'b1));
		directed.push_back(make_req(ACT_KEY_EVENT, 16'h0000, 8'h00, 6'h00, 4'd0, 3'd7, 1'b1));
		directed.push_back(make_req(ACT_KEY_EVENT, 16'h0000, 8'h00, 6'h00, 4'd15, 3'd0, 1'b1));
		// strobe with the high bit, then port reads with all and no extra lines
		directed.push_back(make_req(ACT_CPU_WRITE, 16'h3E00, 8'hFF, 6'h00, 4'h0, 3'h0, 1'b0));
		directed.push_back(make_req(ACT_PORT_READ, 16'h0000, 8'h00, 6'h3F, 4'h0, 3'h0, 1'b0));
		directed.push_back(make_req(ACT_CPU_WRITE, 16'h3FFF, 8'h00, 6'h00, 4'h0, 3'h0, 1'b0));
		directed.push_back(make_req(ACT_PORT_READ, 16'h0000, 8'h00, 6'h3F, 4'h0, 3'h0, 1'b0));
		directed.push_back(make_req(ACT_KEY_EVENT, 16'h0000, 8'h00, 6'h00, 4'd12, 3'd7, 1'b0));
		directed.push_back(make_req(ACT_PORT_READ, 16'h0000, 8'h00, 6'h00, 4'h0, 3'h0, 1'b0));
		foreach (directed[i])
			send_request(directed[i]);

		// random phases: idling style cycles, extended ram toggles between phases
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 83;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 83;
				end
				default: begin
					idle_pct = 21;
					stall_pct = 21;
				end
			endcase
			write_extended_ram(phase % 2 == 0);
			repeat (PhaseRequests)
				send_request(random_request());
		end
		in_valid <= 1'b0;

		// drain what is still owed; a stray result after that counts as an error
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (sb.error_count == 0 && sb.pending() == 0)
			$display("pocket_computer_memory_map_and_keys_tb: PASS");
		else
			$display("pocket_computer_memory_map_and_keys_tb: FAIL");
		$finish;
	end

endmodule
